// ===== rtl/core/brb_pkg.sv =====
// Package with the shared constants, types and helper functions of the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

   // Storage geometry.
   localparam int DEPTH    = 256;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SLOT_W   = ADDR_W + 1;
   localparam int DATA_W   = 8;
   localparam int SIZE_W   = 9;
   localparam int KIND_W   = 3;
   localparam int COUNT_W  = 16;
   localparam int RCOUNT_W = 8;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);

   // Operation codes.
   localparam logic [KIND_W-1:0] KIND_PUT   = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_GET   = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_PEEK  = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_DROP  = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(4);

   // Memory command issued by the pointer control.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } mem_cmd_type;

   // Result fields known before the memory read returns.
   typedef struct packed {
      logic                ok;
      logic                use_rdata;
      logic [RCOUNT_W-1:0] count_out;
      logic                not_empty;
      logic                full_res;
   } meta_type;

   // Add an offset below the slot count to a pointer and wrap it round the ring.
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] ptr,
                                                  input logic [ADDR_W-1:0] offs,
                                                  input logic [SLOT_W-1:0] slots);
      logic [SLOT_W-1:0] sum;
      sum = SLOT_W'(ptr) + SLOT_W'(offs);
      if (sum >= slots) begin
         sum = sum - slots;
      end
      return sum[ADDR_W-1:0];
   endfunction

   // Saturate an occupancy value to the result count width.
   function automatic logic [RCOUNT_W-1:0] sat_count(input logic [ADDR_W-1:0] val);
      logic [RCOUNT_W-1:0] res;
      if (32'(val) > 32'((1 << RCOUNT_W) - 1)) begin
         res = '1;
      end else begin
         res = RCOUNT_W'(val);
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/brb_req_if.sv =====
// Request channel interface of the byte ring buffer.
`timescale 1ns / 1ps

interface brb_req_if;
   logic                          valid;
   logic                          ready;
   logic [brb_pkg::KIND_W-1:0]    kind;
   logic [brb_pkg::DATA_W-1:0]    data_in;
   logic [brb_pkg::COUNT_W-1:0]   count_in;

   modport source (output valid, kind, data_in, count_in, input ready);
   modport sink   (input valid, kind, data_in, count_in, output ready);
endinterface

// ===== rtl/core/brb_rsp_if.sv =====
// Response channel interface of the byte ring buffer.
`timescale 1ns / 1ps

interface brb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [brb_pkg::DATA_W-1:0]    data_out;
   logic [brb_pkg::RCOUNT_W-1:0]  count_out;
   logic                          not_empty;
   logic                          full_res;

   modport source (output valid, ok, data_out, count_out, not_empty, full_res, input ready);
   modport sink   (input valid, ok, data_out, count_out, not_empty, full_res, output ready);
endinterface

// ===== rtl/core/brb_ram.sv =====
// Generic single-address RAM with a registered read port.
`timescale 1ns / 1ps

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; the read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/brb_ptr_ctrl.sv =====
// Pointer control: holds the ring pointers and size, decodes operations and drives the memory.
`timescale 1ns / 1ps

module brb_ptr_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [brb_pkg::KIND_W-1:0]       kind,
   input  logic [brb_pkg::DATA_W-1:0]       data_in,
   input  logic [brb_pkg::COUNT_W-1:0]      count_in,
   input  logic                             csr_write_enable,
   input  logic [brb_pkg::SIZE_W-1:0]       csr_write_data,
   output brb_pkg::mem_cmd_type             mem_cmd,
   output brb_pkg::meta_type                meta
);

   logic [brb_pkg::ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brb_pkg::ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [brb_pkg::SIZE_W-1:0] size_ff;

   logic [brb_pkg::SLOT_W-1:0] slots;
   logic [brb_pkg::ADDR_W-1:0] cap;
   logic [brb_pkg::ADDR_W-1:0] occ;
   logic [brb_pkg::ADDR_W-1:0] occ_after;
   logic [brb_pkg::ADDR_W-1:0] drop_n;
   logic [brb_pkg::SLOT_W-1:0] occ_wide;
   logic                       full_before;
   logic                       empty_before;
   logic                       count_below;

   // Clamp the size register to at least two slots and at most the slots the storage provides.
   always_comb begin
      if (size_ff < brb_pkg::SIZE_MIN) begin
         slots = brb_pkg::SLOT_W'(2);
      end else if (32'(size_ff) > brb_pkg::DEPTH) begin
         slots = brb_pkg::SLOT_W'(brb_pkg::DEPTH);
      end else begin
         slots = brb_pkg::SLOT_W'(size_ff);
      end
   end

   // Occupancy before the operation; the pointers always stay below the slot count.
   always_comb begin
      occ_wide = brb_pkg::SLOT_W'(wr_ptr_ff) - brb_pkg::SLOT_W'(rd_ptr_ff);
      if (wr_ptr_ff < rd_ptr_ff) begin
         occ_wide = occ_wide + slots;
      end
   end

   assign occ          = occ_wide[brb_pkg::ADDR_W-1:0];
   assign cap          = brb_pkg::ADDR_W'(slots - brb_pkg::SLOT_W'(1));
   assign full_before  = (occ == cap);
   assign empty_before = (occ == '0);
   assign count_below  = (count_in < brb_pkg::COUNT_W'(occ));
   assign drop_n       = count_below ? count_in[brb_pkg::ADDR_W-1:0] : occ;

   // Operation decode: next pointers, memory command and result fields.
   always_comb begin
      rd_ptr_in         = rd_ptr_ff;
      wr_ptr_in         = wr_ptr_ff;
      occ_after         = occ;
      mem_cmd.wr_en     = 1'b0;
      mem_cmd.rd_en     = 1'b0;
      mem_cmd.addr      = rd_ptr_ff;
      mem_cmd.wdata     = data_in;
      meta.ok           = 1'b0;
      meta.use_rdata    = 1'b0;
      meta.count_out    = brb_pkg::sat_count(occ);
      case (kind)
         brb_pkg::KIND_PUT: begin
            mem_cmd.addr = wr_ptr_ff;
            if (!full_before) begin
               mem_cmd.wr_en = accept;
               wr_ptr_in     = brb_pkg::wrap_add(wr_ptr_ff, brb_pkg::ADDR_W'(1), slots);
               occ_after     = occ + brb_pkg::ADDR_W'(1);
               meta.ok       = 1'b1;
            end
         end
         brb_pkg::KIND_GET: begin
            if (!empty_before) begin
               mem_cmd.rd_en  = accept;
               rd_ptr_in      = brb_pkg::wrap_add(rd_ptr_ff, brb_pkg::ADDR_W'(1), slots);
               occ_after      = occ - brb_pkg::ADDR_W'(1);
               meta.ok        = 1'b1;
               meta.use_rdata = 1'b1;
            end
         end
         brb_pkg::KIND_PEEK: begin
            mem_cmd.addr = brb_pkg::wrap_add(rd_ptr_ff, count_in[brb_pkg::ADDR_W-1:0], slots);
            if (count_below) begin
               mem_cmd.rd_en  = accept;
               meta.ok        = 1'b1;
               meta.use_rdata = 1'b1;
            end
         end
         brb_pkg::KIND_DROP: begin
            rd_ptr_in      = brb_pkg::wrap_add(rd_ptr_ff, drop_n, slots);
            occ_after      = occ - drop_n;
            meta.count_out = brb_pkg::sat_count(drop_n);
         end
         brb_pkg::KIND_CLEAR: begin
            rd_ptr_in = wr_ptr_ff;
            occ_after = '0;
         end
         default: begin
         end
      endcase
      meta.not_empty = (occ_after != '0);
      meta.full_res  = (occ_after == cap);
   end

   // State update; a size write empties the buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         size_ff   <= brb_pkg::SIZE_RESET;
      end else if (csr_write_enable) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         size_ff   <= csr_write_data;
      end else if (accept) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

endmodule

// ===== rtl/core/byte_ring_buffer.sv =====
// Top level of the byte ring buffer: pointer control, byte store and response stages.
// A result passes the pending stage (memory read), then the output register, after its request transfer.
// Throughput: one request per cycle while responses are taken; set by the single RAM port.
// A stalled response holds the pending stage and blocks new requests until it moves.
// Reset (synchronous): pointers cleared, size set to 256 slots, no response pending.
// The byte store is not cleared; only bytes written by a put are ever read.
`timescale 1ns / 1ps

module byte_ring_buffer (
   input  logic                       clock,
   input  logic                       reset,
   brb_req_if.sink                    req_if,
   brb_rsp_if.source                  rsp_if,
   input  logic                       csr_write_enable,
   input  logic [brb_pkg::SIZE_W-1:0] csr_write_data
);

   brb_pkg::mem_cmd_type       mem_cmd;
   brb_pkg::meta_type          meta;
   brb_pkg::meta_type          pend_meta_ff;
   logic                       pend_valid_ff;
   logic                       pend_move;
   logic                       accept;
   logic [brb_pkg::DATA_W-1:0] rd_data;

   logic                         rsp_valid_ff;
   logic                         rsp_ok_ff;
   logic [brb_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [brb_pkg::RCOUNT_W-1:0] rsp_count_ff;
   logic                         rsp_not_empty_ff;
   logic                         rsp_full_ff;

   // Handshake: the pending stage moves when the output register is free or being taken.
   assign pend_move    = pend_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !pend_valid_ff || pend_move;
   assign accept       = req_if.valid && req_if.ready;

   brb_ptr_ctrl u_ptr_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .kind             (req_if.kind),
      .data_in          (req_if.data_in),
      .count_in         (req_if.count_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mem_cmd          (mem_cmd),
      .meta             (meta)
   );

   brb_ram #(
      .WIDTH (brb_pkg::DATA_W),
      .DEPTH (brb_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .rd_en   (mem_cmd.rd_en),
      .addr    (mem_cmd.addr),
      .wr_data (mem_cmd.wdata),
      .rd_data (rd_data)
   );

   // Pending stage: holds the result fields while the memory read data is registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= 1'b1;
      end else if (pend_move) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_meta_ff <= meta;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload; the byte is zero unless a get or peek succeeded.
   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_ok_ff        <= pend_meta_ff.ok;
         rsp_data_ff      <= pend_meta_ff.use_rdata ? rd_data : '0;
         rsp_count_ff     <= pend_meta_ff.count_out;
         rsp_not_empty_ff <= pend_meta_ff.not_empty;
         rsp_full_ff      <= pend_meta_ff.full_res;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.ok        = rsp_ok_ff;
   assign rsp_if.data_out  = rsp_data_ff;
   assign rsp_if.count_out = rsp_count_ff;
   assign rsp_if.not_empty = rsp_not_empty_ff;
   assign rsp_if.full_res  = rsp_full_ff;

   // A full buffer always holds data, since the capacity is at least one byte.
   a_full_implies_data: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.full_res |-> rsp_if.not_empty)
      else $error("full response reports an empty buffer");

   // One operation never both writes and reads the byte store.
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("byte store written and read in the same cycle");

   // Every request transfer leaves a pending entry in the following cycle.
   a_accept_pending: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_valid_ff)
      else $error("accepted request lost before the pending stage");

   // A returned byte only comes with a successful operation.
   a_data_needs_ok: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && pend_meta_ff.use_rdata |-> pend_meta_ff.ok)
      else $error("read data used for a failed operation");

endmodule
